>>> sv/nsng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsng_pkg
// Shared types, constants and the control program of the 5-smooth number
// generator: one control word per sequencer step.
// ----------------------------------------------------------------------------
package nsng_pkg;

    // Field widths of the stream beats and the default table depth.
    localparam int IDX_W           = 12;
    localparam int IN_TDATA_W      = 16;
    localparam int VAL_W           = 48;
    localparam int MAX_ENTRIES_DEF = 2048;

    // Sequencer steps, in program order.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_VALID = 4'd1,
        ST_CHECK = 4'd2,
        ST_RD3   = 4'd3,
        ST_RD5   = 4'd4,
        ST_MIN   = 4'd5,
        ST_WR    = 4'd6,
        ST_READ  = 4'd7,
        ST_OUT   = 4'd8,
        ST_BAD   = 4'd9
    } t_step;

    // Branch condition: when true go to the target, otherwise as noted per condition.
    typedef enum logic [2:0] {
        CD_NEXT,      // never jump, fall through to the next step
        CD_GOTO,      // always jump
        CD_BAD,       // index is zero or beyond the table
        CD_HAVE,      // the requested entry is already in the table
        CD_IN_BEAT,   // an input beat is accepted, otherwise wait here
        CD_OUT_ROOM   // the output register can take a result, otherwise wait
    } t_cond;

    // Read address source.
    typedef enum logic [1:0] {
        AS_P2,
        AS_P3,
        AS_P5,
        AS_IDX
    } t_asel;

    // Candidate capture.
    typedef enum logic [1:0] {
        CP_NONE,
        CP_C2,
        CP_C3,
        CP_C5
    } t_cap;

    // Output register load.
    typedef enum logic [1:0] {
        OL_NONE,
        OL_HIT,
        OL_BAD
    } t_oload;

    typedef struct packed {
        t_cond  cond;
        t_step  target;
        logic   rd_en;
        t_asel  asel;
        t_cap   cap;
        logic   wr_en;
        t_oload oload;
    } t_ctrl;

    // The control program. Each new entry takes CHECK through WR: five steps.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{cond: CD_NEXT, target: ST_IDLE, rd_en: 1'b0, asel: AS_P2,
              cap: CP_NONE, wr_en: 1'b0, oload: OL_NONE};
        case (step)
            ST_IDLE: begin
                w.cond   = CD_IN_BEAT;
                w.target = ST_VALID;
            end
            ST_VALID: begin
                w.cond   = CD_BAD;
                w.target = ST_BAD;
            end
            ST_CHECK: begin
                w.cond   = CD_HAVE;
                w.target = ST_READ;
                w.rd_en  = 1'b1;
                w.asel   = AS_P2;
            end
            ST_RD3: begin
                w.rd_en = 1'b1;
                w.asel  = AS_P3;
                w.cap   = CP_C2;
            end
            ST_RD5: begin
                w.rd_en = 1'b1;
                w.asel  = AS_P5;
                w.cap   = CP_C3;
            end
            ST_MIN: begin
                w.cap = CP_C5;
            end
            ST_WR: begin
                w.cond   = CD_GOTO;
                w.target = ST_CHECK;
                w.wr_en  = 1'b1;
            end
            ST_READ: begin
                w.rd_en = 1'b1;
                w.asel  = AS_IDX;
            end
            ST_OUT: begin
                w.cond   = CD_OUT_ROOM;
                w.target = ST_IDLE;
                w.oload  = OL_HIT;
            end
            ST_BAD: begin
                w.cond   = CD_OUT_ROOM;
                w.target = ST_IDLE;
                w.oload  = OL_BAD;
            end
            default: begin
                w.cond   = CD_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/nsng_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsng_table
// Single-port-write, single-port-read table of generated terms with a
// registered read.
// ----------------------------------------------------------------------------
module nsng_table #(
    parameter int DEPTH = nsng_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = nsng_pkg::VAL_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered; it holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/nth_smooth_number_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nth_smooth_number_generator
// Returns the n-th (one-based) number whose only prime factors are 2, 3, 5.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_axis side carries a one-based index; each beat on
// the m_axis side carries one answer: the term in tdata and an out-of-range
// flag in tuser (index zero or above MAX_ENTRIES, term then zero).
// The block handles one query at a time and takes a new index only when the
// sequencer is idle. Terms are kept in a table of MAX_ENTRIES words that grows
// only as far as a query needs; a query that is already covered is a plain
// table read.
// Steps: an invalid index goes VALID then BAD; a covered index goes VALID,
// CHECK, READ and OUT. Each term that must be generated first runs CHECK,
// RD3, RD5, MIN and WR: one shared table read port serves the three candidate
// reads, then a min step and a write step. The first query for the last entry
// thus generates every term; later queries for it are plain table reads.
// Reset clears the term count to one and the three pointers to zero; the
// table needs no clearing pass since entry zero reads as the constant one.
// A result waits in the output register while m_axis_tready is low; the next
// index is taken meanwhile and its answer waits at the final step.
// ----------------------------------------------------------------------------
module nth_smooth_number_generator #(
    parameter int MAX_ENTRIES = nsng_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nsng_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [11:0] index
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nsng_pkg::VAL_W-1:0]      m_axis_tdata,   // [47:0] value
    output logic [0:0]                      m_axis_tuser    // [0] out_of_range
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = nsng_pkg::IDX_W + 1;
    localparam int VW = nsng_pkg::VAL_W;

    // Sequencer and datapath registers.
    nsng_pkg::t_step          r_step, n_step;
    nsng_pkg::t_ctrl          ctrl;
    logic [nsng_pkg::IDX_W-1:0] r_index;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_p2, r_p3, r_p5;
    logic [VW-1:0]            r_c2, r_c3, r_c5, r_min23;
    logic                     r_rd_zero;
    logic                     r_out_valid;
    logic [VW-1:0]            r_out_value;
    logic                     r_out_oor;

    logic                     in_beat;
    logic                     out_room;
    logic                     cond_true;
    logic                     idx_bad;
    logic                     have_entry;
    logic [AW-1:0]            rd_addr;
    logic [VW-1:0]            mem_data;
    logic [VW-1:0]            rd_val;
    logic [VW-1:0]            min_all;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_room = !r_out_valid || m_axis_tready;

    // Index checks.
    assign idx_bad    = (r_index == '0) || (XW'(r_index) > XW'(MAX_ENTRIES));
    assign have_entry = (XW'(r_count) >= XW'(r_index)) || (r_count == CW'(MAX_ENTRIES));

    // Control word of the current step.
    always_comb begin
        ctrl = nsng_pkg::ucode(r_step);
    end

    // Branch condition.
    always_comb begin
        case (ctrl.cond)
            nsng_pkg::CD_NEXT:     cond_true = 1'b0;
            nsng_pkg::CD_GOTO:     cond_true = 1'b1;
            nsng_pkg::CD_BAD:      cond_true = idx_bad;
            nsng_pkg::CD_HAVE:     cond_true = have_entry;
            nsng_pkg::CD_IN_BEAT:  cond_true = in_beat;
            nsng_pkg::CD_OUT_ROOM: cond_true = out_room;
            default:               cond_true = 1'b1;
        endcase
    end

    // Next step: jump, wait in place, or fall through.
    always_comb begin
        if (cond_true) begin
            n_step = ctrl.target;
        end else if (ctrl.cond == nsng_pkg::CD_IN_BEAT ||
                     ctrl.cond == nsng_pkg::CD_OUT_ROOM) begin
            n_step = r_step;
        end else begin
            n_step = nsng_pkg::t_step'(4'(r_step) + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= nsng_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Read address select.
    always_comb begin
        case (ctrl.asel)
            nsng_pkg::AS_P2:  rd_addr = r_p2;
            nsng_pkg::AS_P3:  rd_addr = r_p3;
            nsng_pkg::AS_P5:  rd_addr = r_p5;
            nsng_pkg::AS_IDX: rd_addr = AW'(r_index - nsng_pkg::IDX_W'(1));
            default:          rd_addr = r_p2;
        endcase
    end

    nsng_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .DW    (VW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ctrl.wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (min_all),
        .i_rd_en   (ctrl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_data)
    );

    // Entry zero is never written and always reads as one.
    always_ff @(posedge i_clk) begin
        if (ctrl.rd_en) begin
            r_rd_zero <= (rd_addr == '0);
        end
    end

    assign rd_val  = r_rd_zero ? VW'(1) : mem_data;
    assign min_all = (r_c5 < r_min23) ? r_c5 : r_min23;

    // Candidate products, all wrapping at the value width.
    always_ff @(posedge i_clk) begin
        case (ctrl.cap)
            nsng_pkg::CP_C2: r_c2 <= rd_val << 1;
            nsng_pkg::CP_C3: r_c3 <= rd_val + (rd_val << 1);
            nsng_pkg::CP_C5: begin
                r_c5    <= rd_val + (rd_val << 2);
                r_min23 <= (r_c3 < r_c2) ? r_c3 : r_c2;
            end
            default: begin
            end
        endcase
    end

    // Index capture.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_index <= s_axis_tdata[nsng_pkg::IDX_W-1:0];
        end
    end

    // Term count and pointers: every pointer on the minimum advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_p2    <= '0;
            r_p3    <= '0;
            r_p5    <= '0;
        end else if (ctrl.wr_en) begin
            r_count <= r_count + CW'(1);
            if (r_c2 == min_all) begin
                r_p2 <= r_p2 + AW'(1);
            end
            if (r_c3 == min_all) begin
                r_p3 <= r_p3 + AW'(1);
            end
            if (r_c5 == min_all) begin
                r_p5 <= r_p5 + AW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.oload != nsng_pkg::OL_NONE && out_room) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_room) begin
            case (ctrl.oload)
                nsng_pkg::OL_HIT: begin
                    r_out_value <= rd_val;
                    r_out_oor   <= 1'b0;
                end
                nsng_pkg::OL_BAD: begin
                    r_out_value <= '0;
                    r_out_oor   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready   = (r_step == nsng_pkg::ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_value;
    assign m_axis_tuser[0] = r_out_oor;

    // The term count stays between one and the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (XW'(r_count) <= XW'(MAX_ENTRIES)))
        else $error("term count out of range");

    // Every pointer refers to a term already generated.
    a_ptr_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_p2) < r_count) && (CW'(r_p3) < r_count) && (CW'(r_p5) < r_count))
        else $error("pointer beyond generated terms");

    // A new term is only written while the table has room.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wr_en |-> (XW'(r_count) < XW'(MAX_ENTRIES)))
        else $error("table write past its end");

    // Generating a term advances the count by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("term count did not advance");

endmodule

>>> test/nth_smooth_number_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nth_smooth_number_generator_tb
// Self-checking bench for the 5-smooth number generator. Index queries go in
// on the s_axis side with random gaps. Answers come out on the m_axis side
// under random back-pressure and are compared with an in-bench table of terms
// that grows the way the block's own table does.
// ----------------------------------------------------------------------------
module nth_smooth_number_generator_tb;

    localparam int TABLE_DEPTH = nsng_pkg::MAX_ENTRIES_DEF;
    localparam int IW          = nsng_pkg::IDX_W;
    localparam int VW          = nsng_pkg::VAL_W;
    // The slowest answer must first fill the whole table.
    localparam int STALL_LIMIT = 40000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [nsng_pkg::VAL_W-1:0] value;
        logic                       out_of_range;
    } t_answer;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [nsng_pkg::IN_TDATA_W-1:0] s_axis_tdata;   // [11:0] index
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [nsng_pkg::VAL_W-1:0]      m_axis_tdata;   // [47:0] value
    logic [0:0]                      m_axis_tuser;   // [0] out_of_range

    // Bench copy of the term table and its generation pointers.
    logic [nsng_pkg::VAL_W-1:0] smooth_terms [0:TABLE_DEPTH-1];
    int unsigned      term_count;
    logic [10:0]      ptr_two;
    logic [10:0]      ptr_three;
    logic [10:0]      ptr_five;

    t_answer pending_answers[$];
    int      errors;
    int      queries_sent;
    int      bad_queries;
    int      answers_checked;
    int      idle_cycles;
    bit      no_gaps;

    nth_smooth_number_generator #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Answers one query and extends the term table as far as it needs.
    function automatic t_answer compute_answer(input logic [nsng_pkg::IDX_W-1:0] idx);
        t_answer                    ans;
        logic [nsng_pkg::VAL_W-1:0] c2;
        logic [nsng_pkg::VAL_W-1:0] c3;
        logic [nsng_pkg::VAL_W-1:0] c5;
        logic [nsng_pkg::VAL_W-1:0] low;
        ans.value        = '0;
        ans.out_of_range = 1'b1;
        if (idx == 0 || idx > TABLE_DEPTH) begin
            return ans;
        end
        while (term_count < idx) begin
            c2  = smooth_terms[ptr_two] * 2;
            c3  = smooth_terms[ptr_three] * 3;
            c5  = smooth_terms[ptr_five] * 5;
            low = c2;
            if (c3 < low) low = c3;
            if (c5 < low) low = c5;
            smooth_terms[term_count] = low;
            // Every factor that produced the new term moves on, so no term repeats.
            if (c2 == low) ptr_two = ptr_two + 1'b1;
            if (c3 == low) ptr_three = ptr_three + 1'b1;
            if (c5 == low) ptr_five = ptr_five + 1'b1;
            term_count++;
        end
        ans.value        = smooth_terms[idx - 1];
        ans.out_of_range = 1'b0;
        return ans;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Sends one index beat; called and returning at a falling edge.
    task automatic send_index(input logic [nsng_pkg::IDX_W-1:0] idx);
        int gap;
        s_axis_tdata  = {{(nsng_pkg::IN_TDATA_W - nsng_pkg::IDX_W){1'b0}}, idx};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_answers.insert(pending_answers.size(), compute_answer(idx));
        queries_sent++;
        if (idx == 0 || idx > TABLE_DEPTH) bad_queries++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Holds the input side until every outstanding answer has come back.
    task automatic wait_for_answers();
        s_axis_tvalid = 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
    endtask

    // Zero, the all-ones index, indexes just past the table and one further out.
    task automatic test_invalid_indices();
        send_index(12'd0);
        send_index(12'hFFF);
        send_index(IW'(TABLE_DEPTH + 1));
        send_index(12'hAAA);
        send_index(IW'(TABLE_DEPTH + 2));
    endtask

    // The first terms one at a time at full rate, then reads of covered entries.
    task automatic test_first_terms();
        no_gaps = 1'b1;
        send_index(12'd1);
        send_index(12'd1);
        for (int n = 2; n <= 10; n++) begin
            send_index(IW'(n));
        end
        send_index(12'd4);
        send_index(12'd1);
        send_index(12'd10);
        no_gaps = 1'b0;
    endtask

    // A jump in growth, a full drain, then queries from an idle block.
    task automatic test_after_drain();
        send_index(12'd60);
        wait_for_answers();
        send_index(12'd30);
        send_index(12'h555);
        send_index(12'd60);
    endtask

    // Random mix: small growth steps, covered reads and invalid indexes.
    task automatic test_random_queries(input int count);
        int          r;
        int unsigned top;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (n == count / 2) wait_for_answers();
            // Runs of back-to-back beats now and then.
            if (n % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (r < 45 && term_count < TABLE_DEPTH) begin
                top = term_count + $urandom_range(1, 40);
                if (top > TABLE_DEPTH) top = TABLE_DEPTH;
                send_index(IW'($urandom_range(term_count + 1, top)));
            end else if (r < 75) begin
                send_index(IW'($urandom_range(1, term_count)));
            end else if (r < 93) begin
                send_index(IW'($urandom_range(TABLE_DEPTH + 1, 4095)));
            end else begin
                send_index(12'd0);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Fill the whole table in one query, then read both ends of it.
    task automatic test_full_table();
        send_index(IW'(TABLE_DEPTH));
        send_index(IW'(TABLE_DEPTH - 1));
        send_index(IW'(TABLE_DEPTH));
        send_index(12'd1);
        send_index(IW'($urandom_range(1, TABLE_DEPTH)));
    endtask

    // Receiver readiness: runs of ready with short stalls and a few long ones.
    initial begin
        int run;
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 20);
            m_axis_tready = 1'b1;
            repeat (run) @(negedge i_clk);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: stall = $urandom_range(1, 3);
                6, 7, 8:          stall = 0;
                default:          stall = $urandom_range(10, 60);
            endcase
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // Compare each answer beat with the oldest expected answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected answer beat: value %0d, out_of_range %0b",
                       m_axis_tdata, m_axis_tuser[0]);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (m_axis_tdata !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.out_of_range) begin
                    $error("out_of_range: expected %0b, got %0b",
                           want.out_of_range, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Ends the run if neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("** nth_smooth_number_generator: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        errors          = 0;
        queries_sent    = 0;
        bad_queries     = 0;
        answers_checked = 0;
        idle_cycles     = 0;
        no_gaps         = 1'b0;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            smooth_terms[n] = '0;
        end
        smooth_terms[0] = VW'(1);
        term_count      = 1;
        ptr_two         = '0;
        ptr_three       = '0;
        ptr_five        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_invalid_indices();
        test_first_terms();
        test_after_drain();
        test_random_queries(75);
        test_full_table();
        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d queries (%0d out of range) and %0d checked answers;",
                 queries_sent, bad_queries, answers_checked);
        $display("the term table reached %0d of %0d entries.", term_count, TABLE_DEPTH);
        if (errors == 0) begin
            $display("** nth_smooth_number_generator: PASSED **");
        end else begin
            $display("** nth_smooth_number_generator: FAILED **");
        end
        $finish;
    end

endmodule
